// ===== rtl/core/kns_pkg.sv =====
// Shared types and constants for the 0/1 knapsack solver.
package kns_pkg;

    localparam int WEIGHT_BITS   = 10;
    localparam int VALUE_IN_BITS = 16;
    localparam int CAP_BITS      = 10;
    localparam int OUT_BITS      = 24;
    localparam int IN_TDATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CAPACITY = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CAPACITY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WEIGHT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WEIGHT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VALUE    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VALUE    = 3'd6;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_ANSWER,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [CAP_BITS-1:0]      capacity;
        logic [CAP_BITS-1:0]      min_capacity;
        logic [CAP_BITS-1:0]      max_capacity;
        logic [WEIGHT_BITS-1:0]   min_weight;
        logic [WEIGHT_BITS-1:0]   max_weight;
        logic [VALUE_IN_BITS-1:0] min_value;
        logic [VALUE_IN_BITS-1:0] max_value;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [OUT_BITS-1:0] best_value;
        logic                status;
    } t_result;

endpackage

// ===== rtl/core/kns_cfg_regs.sv =====
// Configuration register file of the knapsack solver.
module kns_cfg_regs
    import kns_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity     <= CAP_BITS'(1023);
            r_cfg.min_capacity <= CAP_BITS'(1);
            r_cfg.max_capacity <= CAP_BITS'(1023);
            r_cfg.min_weight   <= WEIGHT_BITS'(1);
            r_cfg.max_weight   <= WEIGHT_BITS'(1023);
            r_cfg.min_value    <= VALUE_IN_BITS'(0);
            r_cfg.max_value    <= VALUE_IN_BITS'(65535);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAPACITY:     r_cfg.capacity     <= i_cfg_data[CAP_BITS-1:0];
                CFG_MIN_CAPACITY: r_cfg.min_capacity <= i_cfg_data[CAP_BITS-1:0];
                CFG_MAX_CAPACITY: r_cfg.max_capacity <= i_cfg_data[CAP_BITS-1:0];
                CFG_MIN_WEIGHT:   r_cfg.min_weight   <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_MAX_WEIGHT:   r_cfg.max_weight   <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_MIN_VALUE:    r_cfg.min_value    <= i_cfg_data[VALUE_IN_BITS-1:0];
                CFG_MAX_VALUE:    r_cfg.max_value    <= i_cfg_data[VALUE_IN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/kns_row_mem.sv =====
// Best-value row memory: two registered read ports, one write port.
module kns_row_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= mem[i_rd_addr_a];
        r_rd_b <= mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/core/kns_sweep.sv =====
// Sequencer and update datapath: row sweep per item, answer read, clearing pass.
module kns_sweep
    import kns_pkg::*;
#(
    parameter int MAX_CAPACITY = 1023,
    parameter int VALUE_BITS   = 16,
    parameter int SUM_BITS     = 24,
    parameter int AW           = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [WEIGHT_BITS-1:0]   i_weight,
    input  logic [VALUE_IN_BITS-1:0] i_value,
    input  logic                     i_last,
    output t_result                  o_res,
    input  logic                     i_res_ready,
    output logic [AW-1:0]            o_rd_addr_a,
    output logic [AW-1:0]            o_rd_addr_b,
    input  logic [SUM_BITS-1:0]      i_rd_data_a,
    input  logic [SUM_BITS-1:0]      i_rd_data_b,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [SUM_BITS-1:0]      o_wr_data
);

    localparam int VKEEP = (VALUE_BITS < VALUE_IN_BITS) ? VALUE_BITS : VALUE_IN_BITS;
    localparam logic [VALUE_IN_BITS-1:0] VMASK =
        VALUE_IN_BITS'((33'd1 << VKEEP) - 33'd1);
    localparam int SW = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
    localparam logic [SW-1:0] SUM_MAX = SW'({SUM_BITS{1'b1}});
    localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_CAPACITY);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_j, n_j;
    logic [AW-1:0]         r_w, n_w;
    logic [VALUE_BITS-1:0] r_v, n_v;
    logic                  r_last, n_last;
    logic                  r_err, n_err;
    logic                  r_wr_vld, n_wr_vld;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;

    logic [VALUE_IN_BITS-1:0] in_v;
    logic                     accept;
    logic                     bad_item;
    logic                     w_fits;
    logic                     bad_cap;
    logic [SW-1:0]            cand;
    logic [SW-1:0]            sat;
    logic                     upd;
    logic [AW-1:0]            cap_addr;

    assign in_v     = i_value & VMASK;
    assign accept   = i_in_valid && o_in_ready;
    assign bad_item = (i_weight < i_cfg.min_weight) || (i_weight > i_cfg.max_weight) ||
                      (in_v < i_cfg.min_value) || (in_v > i_cfg.max_value);
    assign w_fits   = 32'(i_weight) <= 32'(MAX_CAPACITY);
    assign bad_cap  = (i_cfg.capacity < i_cfg.min_capacity) ||
                      (i_cfg.capacity > i_cfg.max_capacity) ||
                      (32'(i_cfg.capacity) > 32'(MAX_CAPACITY));
    assign cap_addr = AW'(i_cfg.capacity);

    // best[j-w] + v, saturated, against best[j]
    assign cand = SW'(i_rd_data_b) + SW'(r_v);
    assign sat  = (cand > SUM_MAX) ? SUM_MAX : cand;
    assign upd  = sat > SW'(i_rd_data_a);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_j == '0) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (!bad_item && w_fits) n_state = ST_SWEEP;
                    else if (i_last)         n_state = ST_ANSWER;
                    else                     n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (r_j == r_w) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_ANSWER : ST_IDLE;
            end
            ST_ANSWER: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_res_ready) n_state = ST_CLEAR;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath registers next values
    always_comb begin
        n_j       = r_j;
        n_w       = r_w;
        n_v       = r_v;
        n_last    = r_last;
        n_err     = r_err;
        n_wr_vld  = 1'b0;
        n_wr_addr = r_j;
        unique case (r_state)
            ST_CLEAR: begin
                n_j = r_j - AW'(1);
                if (r_j == '0) n_err = 1'b0;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_j    = TOP_ADDR;
                    n_w    = AW'(i_weight);
                    n_v    = VALUE_BITS'(in_v);
                    n_last = i_last;
                    if (bad_item) n_err = 1'b1;
                end
            end
            ST_SWEEP: begin
                n_wr_vld = 1'b1;
                if (r_j != r_w) n_j = r_j - AW'(1);
            end
            ST_RESULT: begin
                n_j = TOP_ADDR;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_rd_addr_a      = r_j;
        o_rd_addr_b      = r_j - r_w;
        o_wr_en          = 1'b0;
        o_wr_addr        = r_wr_addr;
        o_wr_data        = SUM_BITS'(sat);
        o_res.valid      = 1'b0;
        o_res.best_value = OUT_BITS'(i_rd_data_a);
        o_res.status     = STATUS_OK;
        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_j;
                o_wr_data = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SWEEP, ST_DRAIN: begin
                o_wr_en = r_wr_vld && upd;
            end
            ST_ANSWER: begin
                o_rd_addr_a = cap_addr;
            end
            ST_RESULT: begin
                o_rd_addr_a = cap_addr;
                o_res.valid = 1'b1;
                if (r_err || bad_cap) begin
                    o_res.best_value = '0;
                    o_res.status     = STATUS_BAD;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_j      <= TOP_ADDR;
            r_err    <= 1'b0;
            r_wr_vld <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_err    <= n_err;
            r_wr_vld <= n_wr_vld;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_v       <= n_v;
        r_wr_addr <= n_wr_addr;
    end

    a_no_pending_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_wr_vld)
        else $error("item accepted while a row write is pending");

    a_sweep_above_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP |-> r_j >= r_w)
        else $error("sweep address below item weight");

    a_result_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && i_res_ready |=> r_state == ST_CLEAR)
        else $error("row not cleared after answer");

    a_idle_error_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE && $past(r_state) == ST_CLEAR |-> !r_err)
        else $error("error flag survived clearing pass");

endmodule

// ===== rtl/core/knapsack_01_dp_top.sv =====
// Top level of the streaming 0/1 knapsack solver.
//
// Input stream: one word per item, tdata holds weight and value, tlast marks
// the last item of a problem. Output stream: one word per problem, sent after
// the last item: tdata holds the best value, tuser the status (1 = invalid
// item or capacity, value then 0).
// Each valid item sweeps the best-value row from MAX_CAPACITY down to its
// weight, one read-modify-write per cycle in the row memory, then passes
// through a drain state; a rejected or too heavy item is dropped in idle.
// A last item adds the answer read and a clearing pass that zeroes all
// MAX_CAPACITY + 1 row entries (1024 by default) before the next item is
// taken. After reset the same clearing pass runs with s_axis_tready low;
// configuration writes are taken at any time.
// The answer sits in an output register; a stalled receiver only blocks
// the next answer, while the following problem's items keep flowing until
// its answer needs the register.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high; write only while the block is idle.
module knapsack_01_dp_top
    import kns_pkg::*;
#(
    parameter int MAX_CAPACITY = 1023,
    parameter int VALUE_BITS   = 16,
    parameter int SUM_BITS     = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,  // item_weight[9:0], item_value[25:10]
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_BITS-1:0]      m_axis_tdata,  // best_value[23:0]
    output logic                     m_axis_tuser   // status
);

    localparam int DEPTH = MAX_CAPACITY + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg                cfg;
    t_result             res;
    logic                res_ready;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;
    logic [SUM_BITS-1:0] rd_data_a;
    logic [SUM_BITS-1:0] rd_data_b;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [SUM_BITS-1:0] wr_data;

    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_value;
    logic                r_out_status;

    kns_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kns_row_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SUM_BITS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data)
    );

    kns_sweep #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .VALUE_BITS   (VALUE_BITS),
        .SUM_BITS     (SUM_BITS),
        .AW           (AW)
    ) u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_weight    (s_axis_tdata[WEIGHT_BITS-1:0]),
        .i_value     (s_axis_tdata[WEIGHT_BITS+VALUE_IN_BITS-1:WEIGHT_BITS]),
        .i_last      (s_axis_tlast),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_value  <= res.best_value;
            r_out_status <= res.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

endmodule
